// File: hw/rtl/fla_pkg.sv
// Package of the free list allocator: sizes, codes, entry type and sequencer states.
// Used by free_list_allocator and tb_free_list_allocator; depends on nothing.
package fla_pkg;

  localparam int unsigned ARENA_BYTES  = 4096;
  localparam int unsigned FREE_ENTRIES = 64;
  localparam int unsigned ARENA_AW     = $clog2(ARENA_BYTES);
  localparam int unsigned TAB_AW       = $clog2(FREE_ENTRIES);
  localparam int unsigned CNT_W        = $clog2(FREE_ENTRIES + 1);
  localparam int unsigned LEN_W        = $clog2(ARENA_BYTES + 1);
  localparam int unsigned NEED_W       = 17;

  localparam logic [2:0] HDR_BYTES = 3'd4;
  localparam logic [7:0] FREE_MARK = 8'h46;
  localparam logic [7:0] CLR_BASE  = 8'd65;
  localparam logic [3:0] CLR_LAST  = 4'd9;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_MAGIC  = 2'd1;
  localparam logic [1:0] CFG_MAXREQ = 2'd2;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_NEXT  = 2'd2;
  localparam logic [1:0] FIT_NONE  = 2'd3;

  localparam logic FUNC_ALLOC = 1'b0;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TOO_BIG  = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_BAD_PTR  = 3'd3;
  localparam logic [2:0] ST_TAB_FULL = 3'd4;

  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [ARENA_AW-1:0] start;
  } tab_entry_t;

  localparam int unsigned ENTRY_W = $bits(tab_entry_t);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_A_CHECK, S_M_LOAD, S_M_RD, S_M_CMP, S_M_END, S_M_FIX,
    S_S_RD, S_S_CMP, S_HDR, S_UPD, S_D_RD, S_D_WR, S_A_FIN,
    S_R_RD, S_R_DAT, S_R_CHK, S_R_MARK, S_I_START, S_I_RD, S_I_CMP, S_I_WR,
    S_RESP
  } state_e;

endpackage

// File: hw/rtl/free_list_allocator.sv
// Top level of the free list allocator: sequencer, arena RAM and free table RAM.
// Depends on fla_pkg and fla_ram.
//
// Channel    Direction  Contents
// s_axis     in         tuser: func; tdata: req_size[15:0], block_addr[27:16]
// m_axis     out        tdata: result_addr[11:0], status[14:12]
// cfg        in         cfg_index_i selects policy, magic_word or max_request
//
// After reset a clearing pass fills the arena; no transaction is taken then.
// An allocate checks the size, merges touching table entries, searches the table,
// writes the header and moves the following entries down when a region is used up.
// A free reads and checks the header, marks it and inserts an entry in order, or is refused.
// Every table step goes through the one free table read port.
// The result register lets a new transaction start while the last result waits.
module free_list_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_size, block_addr, zero fill
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // result_addr, status, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import fla_pkg::*;

  state_e state_q, state_d;

  logic [1:0]  policy_q, policy_d;
  logic [15:0] magic_q, magic_d;
  logic [15:0] maxreq_q, maxreq_d;

  logic [ARENA_AW-1:0] clr_addr_q, clr_addr_d;
  logic [7:0]          clr_val_q, clr_val_d;
  logic [3:0]          clr_mod_q, clr_mod_d;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TAB_AW-1:0] rover_q, rover_d, new_rover_q, new_rover_d;
  logic [CNT_W-1:0]  ri_q, ri_d, wi_q, wi_d, n_q, n_d;
  logic [TAB_AW-1:0] p_q, p_d, k_q, k_d;
  logic              found_q, found_d;
  tab_entry_t        cur_q, cur_d, kent_q, kent_d;
  logic [15:0]       req_q, req_d;
  logic [NEED_W-1:0] need_q, need_d;
  logic [ARENA_AW-1:0] hdr_q, hdr_d;
  logic [1:0]        byte_q, byte_d;
  logic [31:0]       hw_q, hw_d;
  logic [2:0]        status_q, status_d;
  logic [ARENA_AW-1:0] res_q, res_d;

  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q, out_data_d;

  logic                tab_we;
  logic [TAB_AW-1:0]   tab_waddr, tab_raddr;
  tab_entry_t          tab_wdata, e;
  logic [ENTRY_W-1:0]  tab_rdata;
  logic                ar_we;
  logic [ARENA_AW-1:0] ar_waddr, ar_raddr;
  logic [7:0]          ar_wdata, ar_rdata;

  fla_ram #(.Width(ENTRY_W), .Depth(FREE_ENTRIES)) u_tab (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(tab_wdata),
    .raddr_i(tab_raddr), .rdata_o(tab_rdata)
  );

  fla_ram #(.Width(8), .Depth(ARENA_BYTES)) u_arena (
    .clk_i, .we_i(ar_we), .waddr_i(ar_waddr), .wdata_i(ar_wdata),
    .raddr_i(ar_raddr), .rdata_o(ar_rdata)
  );

  assign e = tab_entry_t'(tab_rdata);

  logic              in_acc, resp_go;
  logic              touch, fit, take, stop, last_n;
  logic [LEN_W-1:0]  cur_end, new_len;
  logic [TAB_AW-1:0] rover_fix, rover_upd;
  logic [NEED_W-1:0] free_len;
  logic [17:0]       free_end;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign resp_go = !out_valid_q || m_axis_tready;
  assign cur_end = {1'b0, cur_q.start} + cur_q.len;
  assign touch   = cur_end == {1'b0, e.start};
  assign fit     = {{(NEED_W-LEN_W){1'b0}}, e.len} >= need_q;
  assign take    = fit && (!found_q || (policy_q == FIT_BEST && e.len < kent_q.len));
  assign last_n  = (n_q + 1'b1) == cnt_q;
  assign stop    = (policy_q != FIT_BEST && fit) || last_n;
  assign new_len = kent_q.len - need_q[LEN_W-1:0];
  assign rover_fix = ({1'b0, rover_q} >= cnt_q) ? '0 : rover_q;
  assign free_len  = {1'b0, hw_q[31:16]} + NEED_W'(HDR_BYTES);
  assign free_end  = {6'b0, hdr_q} + {1'b0, free_len};

  always_comb begin
    rover_upd = (policy_q == FIT_NEXT) ? k_q : rover_q;
    if (new_len == '0 && rover_upd > k_q) begin
      rover_upd = rover_upd - 1'b1;
    end
  end

  assign s_axis_tready = state_q == S_IDLE;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_addr_q == ARENA_AW'(ARENA_BYTES - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser == FUNC_ALLOC) ? S_A_CHECK : S_R_RD;
        end
      end
      S_A_CHECK: begin
        if (need_q >= {1'b0, maxreq_q}) state_d = S_RESP;
        else if (cnt_q == '0) state_d = S_M_FIX;
        else state_d = S_M_LOAD;
      end
      S_M_LOAD: state_d = (cnt_q == CNT_W'(1)) ? S_M_FIX : S_M_RD;
      S_M_RD:   state_d = S_M_CMP;
      S_M_CMP:  state_d = ((ri_q + 1'b1) == cnt_q) ? S_M_END : S_M_RD;
      S_M_END:  state_d = S_M_FIX;
      S_M_FIX:  state_d = (policy_q == FIT_NONE || cnt_q == '0) ? S_RESP : S_S_RD;
      S_S_RD:   state_d = S_S_CMP;
      S_S_CMP: begin
        if (stop) state_d = (found_q || fit) ? S_HDR : S_RESP;
        else state_d = S_S_RD;
      end
      S_HDR: if (byte_q == 2'd3) state_d = S_UPD;
      S_UPD: begin
        if (new_len != '0 || ({1'b0, k_q} + 1'b1) == cnt_q) state_d = S_A_FIN;
        else state_d = S_D_RD;
      end
      S_D_RD:  state_d = S_D_WR;
      S_D_WR:  state_d = ((ri_q + 1'b1) == cnt_q) ? S_A_FIN : S_D_RD;
      S_A_FIN: state_d = S_RESP;
      S_R_RD:  state_d = S_R_DAT;
      S_R_DAT: state_d = (byte_q == 2'd3) ? S_R_CHK : S_R_RD;
      S_R_CHK: begin
        if (hw_q[15:0] != magic_q || free_end > 18'(ARENA_BYTES)) state_d = S_RESP;
        else if (cnt_q == CNT_W'(FREE_ENTRIES)) state_d = S_RESP;
        else state_d = S_R_MARK;
      end
      S_R_MARK:  if (byte_q == 2'd3) state_d = S_I_START;
      S_I_START: state_d = (cnt_q == '0) ? S_I_WR : S_I_RD;
      S_I_RD:    state_d = S_I_CMP;
      S_I_CMP: begin
        if (e.start > hdr_q && ri_q != '0) state_d = S_I_RD;
        else state_d = S_I_WR;
      end
      S_I_WR: state_d = S_RESP;
      S_RESP: if (resp_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    policy_d = policy_q;
    magic_d  = magic_q;
    maxreq_d = maxreq_q;
    clr_addr_d = clr_addr_q;
    clr_val_d  = clr_val_q;
    clr_mod_d  = clr_mod_q;
    cnt_d = cnt_q;
    rover_d = rover_q;
    new_rover_d = new_rover_q;
    ri_d = ri_q;
    wi_d = wi_q;
    n_d = n_q;
    p_d = p_q;
    k_d = k_q;
    found_d = found_q;
    cur_d = cur_q;
    kent_d = kent_q;
    req_d = req_q;
    need_d = need_q;
    hdr_d = hdr_q;
    byte_d = byte_q;
    hw_d = hw_q;
    status_d = status_q;
    res_d = res_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d = out_data_q;
    tab_we = 1'b0;
    tab_waddr = '0;
    tab_wdata = cur_q;
    tab_raddr = '0;
    ar_we = 1'b0;
    ar_waddr = '0;
    ar_wdata = FREE_MARK;
    ar_raddr = '0;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_POLICY: policy_d = cfg_data_i[1:0];
        CFG_MAGIC:  magic_d  = cfg_data_i;
        CFG_MAXREQ: maxreq_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_CLEAR: begin
        ar_we = 1'b1;
        ar_waddr = clr_addr_q;
        ar_wdata = clr_val_q;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_mod_q == CLR_LAST) begin
          clr_mod_d = '0;
          clr_val_d = clr_val_q + 1'b1;
        end else begin
          clr_mod_d = clr_mod_q + 1'b1;
        end
        tab_we = clr_addr_q == '0;
        tab_wdata.len = LEN_W'(ARENA_BYTES);
        tab_wdata.start = '0;
      end
      S_IDLE: begin
        req_d = s_axis_tdata[15:0];
        need_d = {1'b0, s_axis_tdata[15:0]} + NEED_W'(HDR_BYTES);
        hdr_d = s_axis_tdata[16 +: ARENA_AW] - ARENA_AW'(HDR_BYTES);
        byte_d = '0;
        res_d = '0;
      end
      S_A_CHECK: begin
        status_d = ST_TOO_BIG;
        tab_raddr = '0;
        new_rover_d = rover_q;
      end
      S_M_LOAD: begin
        cur_d = e;
        ri_d = CNT_W'(1);
        wi_d = '0;
      end
      S_M_RD: tab_raddr = ri_q[TAB_AW-1:0];
      S_M_CMP: begin
        if (touch) begin
          cur_d.len = cur_q.len + e.len;
          if ({1'b0, rover_q} == ri_q) new_rover_d = wi_q[TAB_AW-1:0];
        end else begin
          tab_we = 1'b1;
          tab_waddr = wi_q[TAB_AW-1:0];
          wi_d = wi_q + 1'b1;
          cur_d = e;
          if ({1'b0, rover_q} == ri_q) new_rover_d = TAB_AW'(wi_q + 1'b1);
        end
        ri_d = ri_q + 1'b1;
      end
      S_M_END: begin
        tab_we = 1'b1;
        tab_waddr = wi_q[TAB_AW-1:0];
        cnt_d = wi_q + 1'b1;
        rover_d = new_rover_q;
      end
      S_M_FIX: begin
        rover_d = rover_fix;
        status_d = ST_NO_FIT;
        p_d = (policy_q == FIT_NEXT) ? rover_fix : '0;
        n_d = '0;
        found_d = 1'b0;
        byte_d = '0;
      end
      S_S_RD: tab_raddr = p_q;
      S_S_CMP: begin
        if (take) begin
          k_d = p_q;
          kent_d = e;
          found_d = 1'b1;
        end
        p_d = (({1'b0, p_q} + 1'b1) == cnt_q) ? '0 : p_q + 1'b1;
        n_d = n_q + 1'b1;
      end
      S_HDR: begin
        ar_we = 1'b1;
        ar_waddr = kent_q.start + ARENA_AW'(byte_q);
        case (byte_q)
          2'd0:    ar_wdata = req_q[15:8];
          2'd1:    ar_wdata = req_q[7:0];
          2'd2:    ar_wdata = magic_q[15:8];
          default: ar_wdata = magic_q[7:0];
        endcase
        byte_d = byte_q + 1'b1;
      end
      S_UPD: begin
        res_d = kent_q.start + ARENA_AW'(HDR_BYTES);
        status_d = ST_OK;
        rover_d = rover_upd;
        tab_waddr = k_q;
        tab_wdata.len = new_len;
        tab_wdata.start = kent_q.start + need_q[ARENA_AW-1:0];
        ri_d = {1'b0, k_q} + 1'b1;
        if (new_len != '0) begin
          tab_we = 1'b1;
        end else if (({1'b0, k_q} + 1'b1) == cnt_q) begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_D_RD: tab_raddr = ri_q[TAB_AW-1:0];
      S_D_WR: begin
        tab_we = 1'b1;
        tab_waddr = TAB_AW'(ri_q - 1'b1);
        tab_wdata = e;
        ri_d = ri_q + 1'b1;
        if ((ri_q + 1'b1) == cnt_q) cnt_d = cnt_q - 1'b1;
      end
      S_A_FIN: rover_d = rover_fix;
      S_R_RD: ar_raddr = hdr_q + ARENA_AW'(byte_q);
      S_R_DAT: begin
        hw_d = {hw_q[23:0], ar_rdata};
        byte_d = byte_q + 1'b1;
      end
      S_R_CHK: begin
        need_d = free_len;
        byte_d = '0;
        if (hw_q[15:0] != magic_q || free_end > 18'(ARENA_BYTES)) status_d = ST_BAD_PTR;
        else if (cnt_q == CNT_W'(FREE_ENTRIES)) status_d = ST_TAB_FULL;
        else status_d = ST_OK;
      end
      S_R_MARK: begin
        ar_we = 1'b1;
        ar_waddr = hdr_q + ARENA_AW'(byte_q);
        byte_d = byte_q + 1'b1;
      end
      S_I_START: begin
        ri_d = cnt_q - 1'b1;
        wi_d = '0;
      end
      S_I_RD: tab_raddr = ri_q[TAB_AW-1:0];
      S_I_CMP: begin
        if (e.start > hdr_q) begin
          tab_we = 1'b1;
          tab_waddr = TAB_AW'(ri_q + 1'b1);
          tab_wdata = e;
          wi_d = ri_q;
          ri_d = ri_q - 1'b1;
        end else begin
          wi_d = ri_q + 1'b1;
        end
      end
      S_I_WR: begin
        tab_we = 1'b1;
        tab_waddr = wi_q[TAB_AW-1:0];
        tab_wdata.len = need_q[LEN_W-1:0];
        tab_wdata.start = hdr_q;
        if (cnt_q != '0 && {1'b0, rover_q} >= wi_q) rover_d = rover_q + 1'b1;
        cnt_d = cnt_q + 1'b1;
      end
      S_RESP: begin
        if (resp_go) begin
          out_valid_d = 1'b1;
          out_data_d = {1'b0, status_q, (status_q == ST_OK) ? res_q : '0};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      policy_q <= FIT_FIRST;
      magic_q <= 16'd48879;
      maxreq_q <= 16'd4096;
      clr_addr_q <= '0;
      clr_val_q <= CLR_BASE;
      clr_mod_q <= '0;
      cnt_q <= CNT_W'(1);
      rover_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      policy_q <= policy_d;
      magic_q <= magic_d;
      maxreq_q <= maxreq_d;
      clr_addr_q <= clr_addr_d;
      clr_val_q <= clr_val_d;
      clr_mod_q <= clr_mod_d;
      cnt_q <= cnt_d;
      rover_q <= rover_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_rover_q <= new_rover_d;
    ri_q <= ri_d;
    wi_q <= wi_d;
    n_q <= n_d;
    p_q <= p_d;
    k_q <= k_d;
    found_q <= found_d;
    cur_q <= cur_d;
    kent_q <= kent_d;
    req_q <= req_d;
    need_q <= need_d;
    hdr_q <= hdr_d;
    byte_q <= byte_d;
    hw_q <= hw_d;
    status_q <= status_d;
    res_q <= res_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: hw/rtl/fla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used by free_list_allocator for the arena and the free table.
module fla_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sim/tb_free_list_allocator.sv
// Self-checking testbench of free_list_allocator: stream stimulus, cfg writes and a scoreboard.
// The scoreboard predicts every result from its own copy of the arena and the free table.
// Depends on fla_pkg and the RTL of free_list_allocator.
module tb_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fla_pkg::*;

  typedef struct {
    logic [11:0] addr;
    logic [2:0]  status;
  } alloc_result_t;

  class alloc_scoreboard;
    byte unsigned  arena[ARENA_BYTES];
    int unsigned   fstart[FREE_ENTRIES];
    int unsigned   flen[FREE_ENTRIES];
    int unsigned   fcount;
    int unsigned   rover;
    int unsigned   fit_policy;
    int unsigned   magic;
    int unsigned   max_req;
    alloc_result_t expected_q[$];
    int            errors;
    int unsigned   status_seen[5];

    function new();
      for (int i = 0; i < ARENA_BYTES; i++) arena[i] = 8'((65 + i / 10) & 8'hFF);
      foreach (fstart[i]) begin
        fstart[i] = 0;
        flen[i] = 0;
      end
      flen[0] = ARENA_BYTES;
      fcount = 1;
      rover = 0;
      fit_policy = FIT_FIRST;
      magic = 48879;
      max_req = 4096;
      errors = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_POLICY: fit_policy = val[1:0];
        CFG_MAGIC:  magic = val;
        CFG_MAXREQ: max_req = val;
        default: ;
      endcase
    endfunction

    function void drop_entry(int unsigned j);
      if (j >= fcount) return;
      for (int unsigned k = j; k + 1 < fcount; k++) begin
        fstart[k] = fstart[k+1];
        flen[k] = flen[k+1];
      end
      fcount--;
      if (rover > j) rover--;
    endfunction

    function void add_entry(int unsigned s, int unsigned l);
      int unsigned j;
      j = 0;
      while (j < fcount && fstart[j] <= s) j++;
      for (int unsigned k = fcount; k > j; k--) begin
        fstart[k] = fstart[k-1];
        flen[k] = flen[k-1];
      end
      fstart[j] = s;
      flen[j] = l;
      if (fcount > 0 && rover >= j) rover++;
      fcount++;
    endfunction

    function void merge_touching();
      int unsigned i;
      i = 0;
      while (i + 1 < fcount) begin
        if (fstart[i] + flen[i] == fstart[i+1]) begin
          flen[i] += flen[i+1];
          if (rover == i + 1) rover = i;
          drop_entry(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    function logic [2:0] allocate(int unsigned size, output int unsigned addr);
      int unsigned need, k, s, p;
      bit found;
      need = size + 4;
      k = 0;
      found = 0;
      addr = 0;
      if (need >= max_req) return ST_TOO_BIG;
      merge_touching();
      if (rover >= fcount) rover = 0;
      if (fit_policy == FIT_FIRST) begin
        for (int unsigned i = 0; i < fcount && !found; i++)
          if (flen[i] >= need) begin
            k = i;
            found = 1;
          end
      end else if (fit_policy == FIT_BEST) begin
        for (int unsigned i = 0; i < fcount; i++)
          if (flen[i] >= need && (!found || flen[i] < flen[k])) begin
            k = i;
            found = 1;
          end
      end else if (fit_policy == FIT_NEXT) begin
        p = rover;
        for (int unsigned i = 0; i < fcount && !found; i++) begin
          if (flen[p] >= need) begin
            k = p;
            found = 1;
          end
          p++;
          if (p >= fcount) p = 0;
        end
      end else begin
        return ST_NO_FIT;
      end
      if (!found) return ST_NO_FIT;
      s = fstart[k];
      arena[s % ARENA_BYTES] = 8'((size >> 8) & 8'hFF);
      arena[(s + 1) % ARENA_BYTES] = 8'(size & 8'hFF);
      arena[(s + 2) % ARENA_BYTES] = 8'((magic >> 8) & 8'hFF);
      arena[(s + 3) % ARENA_BYTES] = 8'(magic & 8'hFF);
      addr = (s + 4) % ARENA_BYTES;
      fstart[k] = s + need;
      flen[k] -= need;
      if (fit_policy == FIT_NEXT) rover = k;
      if (flen[k] == 0) drop_entry(k);
      if (rover >= fcount) rover = 0;
      return ST_OK;
    endfunction

    function logic [2:0] release_block(int unsigned ba);
      int unsigned hdr, len;
      hdr = (ba % ARENA_BYTES + ARENA_BYTES - 4) % ARENA_BYTES;
      if ({arena[(hdr + 2) % ARENA_BYTES], arena[(hdr + 3) % ARENA_BYTES]} != magic)
        return ST_BAD_PTR;
      len = {arena[hdr], arena[(hdr + 1) % ARENA_BYTES]} + 4;
      if (hdr + len > ARENA_BYTES) return ST_BAD_PTR;
      if (fcount >= FREE_ENTRIES) return ST_TAB_FULL;
      for (int i = 0; i < 4; i++) arena[(hdr + i) % ARENA_BYTES] = FREE_MARK;
      add_entry(hdr, len);
      return ST_OK;
    endfunction

    function alloc_result_t note_request(logic func, logic [15:0] size, logic [11:0] ba);
      alloc_result_t r;
      int unsigned a;
      a = 0;
      if (func == FUNC_ALLOC) r.status = allocate(size, a);
      else r.status = release_block(ba);
      r.addr = (r.status == ST_OK && func == FUNC_ALLOC) ? a[11:0] : 12'd0;
      expected_q = {expected_q, r};
      return r;
    endfunction

    function void check_result(logic [11:0] addr, logic [2:0] status);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: result_addr %0d status %0d", addr, status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (addr !== e.addr) begin
        $error("result_addr: expected %0d, actual %0d", e.addr, addr);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (e.status <= ST_TAB_FULL) status_seen[e.status]++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  alloc_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_cnt = 0;
  int unsigned     live_q[$];
  int unsigned     n_items = 0;

  free_list_allocator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[11:0], m_axis_tdata[14:12]);
  end

  initial begin
    #30_000_000;
    $display("free_list_allocator regression: fail");
    $finish;
  end

  task automatic send_req(logic func, logic [15:0] size, logic [11:0] ba);
    alloc_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {4'd0, ba, size};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = sb.note_request(func, size, ba);
    n_items++;
    if (func == FUNC_ALLOC && r.status == ST_OK) live_q = {live_q, 32'(r.addr)};
    if (func != FUNC_ALLOC && r.status == ST_TAB_FULL) live_q = {live_q, 32'(ba)};
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic free_live();
    int unsigned idx, a;
    idx = $urandom_range(live_q.size() - 1);
    a = live_q[idx];
    live_q.delete(idx);
    send_req(1'b1, 16'($urandom), a[11:0]);
  endtask

  task automatic random_item();
    int unsigned r, q;
    logic [15:0] size;
    r = $urandom_range(99);
    q = $urandom_range(99);
    if (live_q.size() == 0 || r < 50) begin
      if (q < 60) size = 16'($urandom_range(48));
      else if (q < 90) size = 16'($urandom_range(400));
      else if (q < 97) size = 16'($urandom_range(2000));
      else size = 16'($urandom);
      send_req(FUNC_ALLOC, size, 12'($urandom));
    end else if (r < 93) begin
      free_live();
    end else begin
      send_req(1'b1, 16'($urandom), 12'($urandom_range(4095)));
    end
  endtask

  initial begin
    int unsigned fill_q[$];
    int unsigned n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_POLICY, 16'(FIT_FIRST));
    write_reg(CFG_MAGIC, 16'hFFFF);
    write_reg(CFG_MAXREQ, 16'hFFFF);
    send_req(FUNC_ALLOC, 16'd4088, 12'd0);
    send_req(FUNC_ALLOC, 16'd0, 12'd0);
    send_req(1'b1, 16'd0, 12'd0);
    send_req(1'b1, 16'hFFFF, 12'd4);
    send_req(FUNC_ALLOC, 16'hFFFF, 12'hFFF);
    send_req(FUNC_ALLOC, 16'd65532, 12'd0);
    send_req(FUNC_ALLOC, 16'd5000, 12'd0);
    send_req(1'b1, 16'd0, 12'd4);
    send_req(1'b1, 16'd0, 12'hFFF);
    drain();
    write_reg(CFG_MAXREQ, 16'd5);
    send_req(FUNC_ALLOC, 16'd0, 12'd0);
    send_req(FUNC_ALLOC, 16'd1, 12'd0);
    drain();
    write_reg(CFG_POLICY, 16'(FIT_NONE));
    write_reg(CFG_MAGIC, 16'h0000);
    write_reg(CFG_MAXREQ, 16'd4096);
    send_req(FUNC_ALLOC, 16'd8, 12'd0);
    drain();
    write_reg(CFG_POLICY, 16'(FIT_BEST));
    send_req(FUNC_ALLOC, 16'd12, 12'd0);
    send_req(FUNC_ALLOC, 16'd3, 12'd0);
    while (live_q.size() > 0) free_live();
    drain();

    write_reg(CFG_POLICY, 16'(FIT_FIRST));
    write_reg(CFG_MAGIC, 16'h1234);
    repeat (140) begin
      send_req(FUNC_ALLOC, 16'd0, 12'd0);
    end
    fill_q = live_q;
    live_q.delete();
    n = 0;
    foreach (fill_q[i]) begin
      if (i % 2 == 0) send_req(1'b1, 16'd0, fill_q[i][11:0]);
      else live_q = {live_q, fill_q[i]};
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          write_reg(CFG_POLICY, 16'(FIT_FIRST));
          write_reg(CFG_MAXREQ, 16'd4096);
        end
        1: begin
          send_idle_pct = 86;
          recv_stall_pct = 0;
          write_reg(CFG_POLICY, 16'(FIT_BEST));
          write_reg(CFG_MAXREQ, 16'($urandom_range(65535, 1000)));
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 86;
          write_reg(CFG_POLICY, 16'(FIT_NEXT));
          write_reg(CFG_MAXREQ, 16'd4096);
        end
        default: begin
          send_idle_pct = 20;
          recv_stall_pct = 20;
          write_reg(CFG_POLICY, 16'($urandom_range(2)));
        end
      endcase
      repeat (55) random_item();
      if (ph == 2) begin
        n = recv_stall_pct;
        recv_stall_pct = 0;
        hold_cnt = 3000;
        repeat (12) random_item();
        recv_stall_pct = n;
        drain();
      end
      repeat (55) random_item();
      drain();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d transactions over all fit policies, idle and stall patterns.",
             n_items);
    $display("Statuses seen: ok %0d, too large %0d, no fit %0d, bad pointer %0d, full %0d.",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("free_list_allocator regression: pass");
    end else begin
      $display("free_list_allocator regression: fail");
    end
    $finish;
  end

endmodule
